@@ src/tfa_pkg.sv @@
// Shared constants and types for the temporal frame averager.
`default_nettype none

package tfa_pkg;

	localparam int MAX_PIXELS = 262144;
	localparam int MAX_FRAMES = 256;

	localparam int POS_W  = $clog2(MAX_PIXELS);
	localparam int PIX_W  = 8;
	localparam int SUM_W  = 16;
	localparam int FC_W   = 9;
	localparam int FP_W   = 19;
	localparam int STEP_W = $clog2(SUM_W + 1);

	// Work handed from the store read stage to the averaging divider.
	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [FC_W-1:0]  count;
		logic             ready;
		logic             last;
	} div_req_t;

endpackage

`default_nettype wire

@@ src/tfa_div.sv @@
// Restoring divider with round-half-even and the registered result stage.
`default_nettype none

module tfa_div import tfa_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire div_req_t         req,
	output logic                  idle,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [PIX_W-1:0]      average,
	output logic                  ready_res,
	output logic                  last_pixel
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic [SUM_W-1:0]  quo_q;
	logic [FC_W-1:0]   rem_q;
	logic [FC_W-1:0]   dsr_q;
	logic              rdy_q;
	logic              last_q;
	logic              out_valid_q;
	logic [PIX_W-1:0]  avg_q;
	logic              rdy_out_q;
	logic              last_out_q;

	logic [FC_W:0]     trial;
	logic [FC_W:0]     diff;
	logic              ge;
	logic [FC_W-1:0]   rem_nxt;
	logic [FC_W:0]     rem2;
	logic [FC_W:0]     dsr_x;
	logic              round_up;
	logic [SUM_W:0]    q_inc;
	logic [PIX_W-1:0]  avg_nxt;
	logic              take;
	logic              out_free;
	logic              load;

	always_comb begin
		dsr_x   = {1'b0, dsr_q};
		trial   = {rem_q, quo_q[SUM_W-1]};
		ge      = (trial >= dsr_x);
		diff    = trial - dsr_x;
		rem_nxt = ge ? diff[FC_W-1:0] : trial[FC_W-1:0];

		// The remainder is below the divisor, so doubling it fits one extra bit.
		rem2     = {rem_q, 1'b0};
		round_up = (rem2 > dsr_x) || ((rem2 == dsr_x) && quo_q[0]);
		q_inc    = {1'b0, quo_q} + (SUM_W+1)'(round_up);
		if (dsr_q == '0) begin
			avg_nxt = '0;
		end else if (q_inc > (SUM_W+1)'({PIX_W{1'b1}})) begin
			avg_nxt = {PIX_W{1'b1}};
		end else begin
			avg_nxt = q_inc[PIX_W-1:0];
		end
	end

	assign take     = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign load     = (state_q == ST_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			quo_q       <= '0;
			rem_q       <= '0;
			dsr_q       <= '0;
			rdy_q       <= 1'b0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
			avg_q       <= '0;
			rdy_out_q   <= 1'b0;
			last_out_q  <= 1'b0;
		end else begin
			out_valid_q <= load || (out_valid_q && !take);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						quo_q   <= req.sum;
						rem_q   <= '0;
						dsr_q   <= req.count;
						rdy_q   <= req.ready;
						last_q  <= req.last;
						step_q  <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					quo_q  <= {quo_q[SUM_W-2:0], ge};
					rem_q  <= rem_nxt;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(SUM_W - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// A finished quotient waits here while the previous result is held.
					if (out_free) begin
						avg_q      <= avg_nxt;
						rdy_out_q  <= rdy_q;
						last_out_q <= last_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign idle       = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign average    = avg_q;
	assign ready_res  = rdy_out_q;
	assign last_pixel = last_out_q;

endmodule

`default_nettype wire

@@ src/temporal_frame_averager_unit.sv @@
// Top level of the temporal frame averager: control, frame store and configuration port.
//
//   channel   direction  handshake             payload
//   in        sink       in_valid / in_stall   command, pixel, moved
//   out       source     out_valid / out_stall average, ready_res, last_pixel
//   apb       slave      psel, penable, pready frame_pixels (0x0), min_frames (0x4)
//
// Accumulate and clear transfers may follow back to back;
// the store read-modify-write is bypassed when consecutive pixels hit the same entry.
// A read transfer stalls all input until the 16-step restoring divider is idle again;
// a finished result waits in the output register without blocking input.
// Reset clears the control state only; store entries are undefined until written.
// out_stall holds the result; a following read then waits in the divider once finished
// and stalls all input until the held result is taken.
`default_nettype none

module temporal_frame_averager_unit import tfa_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [1:0]       command,
	input  wire logic [PIX_W-1:0] pixel,
	input  wire logic             moved,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [PIX_W-1:0]      average,
	output logic                  ready_res,
	output logic                  last_pixel,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam logic [1:0] CMD_ACC   = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic REG_FRAME_PIXELS = 1'b0;
	localparam logic REG_MIN_FRAMES   = 1'b1;

	localparam logic [FP_W-1:0] FP_RESET  = FP_W'(262144);
	localparam logic [FC_W-1:0] MIN_RESET = FC_W'(4);

	// Configuration.
	logic [FP_W-1:0] frame_pixels_q;
	logic [FC_W-1:0] min_frames_q;
	logic            cfg_wr;

	// Frame state.
	logic [POS_W-1:0] pos_q;
	logic [FC_W-1:0]  fc_q;
	logic             drop_q;

	// Store and read stage.
	logic [SUM_W-1:0] sum_store_q [MAX_PIXELS];
	logic [SUM_W-1:0] rdata_q;
	logic             wr_s1;
	logic             rd_s1;
	logic             ovr_s1;
	logic [PIX_W-1:0] pix_s1;
	logic [POS_W-1:0] addr_s1;
	logic [FC_W-1:0]  cnt_s1;
	logic             rdy_s1;
	logic             last_s1;
	logic             fwd_vld_q;
	logic [POS_W-1:0] fwd_addr_q;
	logic [SUM_W-1:0] fwd_data_q;

	logic             in_acc;
	logic [POS_W-1:0] last_idx;
	logic             last_hit;
	logic [POS_W-1:0] pos_nxt;
	logic             start;
	logic             drop_n;
	logic [FC_W-1:0]  fc_mid;
	logic [FC_W-1:0]  fc_acc;
	logic             ready_now;
	logic [SUM_W-1:0] sum_s1;
	logic [SUM_W-1:0] wdata;
	div_req_t         div_req;
	logic             div_idle;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pixels_q <= FP_RESET;
			min_frames_q   <= MIN_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_FRAME_PIXELS: frame_pixels_q <= pwdata[FP_W-1:0];
				REG_MIN_FRAMES:   min_frames_q   <= pwdata[FC_W-1:0];
				default: ;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_MIN_FRAMES) ? 32'(min_frames_q) : 32'(frame_pixels_q);

	// Frame position and count.
	always_comb begin
		if (frame_pixels_q == '0) begin
			last_idx = '0;
		end else if (32'(frame_pixels_q) > 32'(MAX_PIXELS)) begin
			last_idx = POS_W'(MAX_PIXELS - 1);
		end else begin
			last_idx = POS_W'(frame_pixels_q - FP_W'(1));
		end
		last_hit = (pos_q >= last_idx);
		pos_nxt  = last_hit ? '0 : pos_q + POS_W'(1);

		// The first pixel of a later frame decides whether the whole frame is dropped.
		start  = (pos_q == '0);
		drop_n = start ? ((fc_q != '0) && (moved || (fc_q >= FC_W'(MAX_FRAMES)))) : drop_q;
		fc_mid = (start && (fc_q != '0) && moved) ? '0 : fc_q;
		if (last_hit && !drop_n && (fc_mid < FC_W'(MAX_FRAMES))) begin
			fc_acc = fc_mid + FC_W'(1);
		end else begin
			fc_acc = fc_mid;
		end
		ready_now = (fc_q != '0) && (fc_q >= min_frames_q);
	end

	assign in_stall = rd_s1 || !div_idle;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fc_q   <= '0;
			drop_q <= 1'b0;
		end else if (in_acc) begin
			unique case (command)
				CMD_ACC: begin
					pos_q  <= pos_nxt;
					fc_q   <= fc_acc;
					drop_q <= drop_n;
				end
				CMD_READ: begin
					pos_q <= pos_nxt;
				end
				CMD_CLEAR: begin
					pos_q  <= '0;
					fc_q   <= '0;
					drop_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// Read stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
			rd_s1 <= 1'b0;
		end else begin
			wr_s1 <= in_acc && (command == CMD_ACC) && !drop_n;
			rd_s1 <= in_acc && (command == CMD_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ovr_s1  <= (fc_mid == '0);
			pix_s1  <= pixel;
			addr_s1 <= pos_q;
			cnt_s1  <= fc_q;
			rdy_s1  <= ready_now;
			last_s1 <= last_hit;
		end
	end

	// Frame store: read on transfer, written back in the following cycle.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rdata_q <= sum_store_q[pos_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_s1) begin
			sum_store_q[addr_s1] <= wdata;
		end
	end

	// The latest write is kept so that a read issued in the same cycle sees it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (wr_s1) begin
			fwd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_s1) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= wdata;
		end
	end

	assign sum_s1 = (fwd_vld_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rdata_q;
	assign wdata  = ovr_s1 ? SUM_W'(pix_s1) : sum_s1 + SUM_W'(pix_s1);

	assign div_req = '{sum: sum_s1, count: cnt_s1, ready: rdy_s1, last: last_s1};

	tfa_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (rd_s1),
		.req        (div_req),
		.idle       (div_idle),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.average    (average),
		.ready_res  (ready_res),
		.last_pixel (last_pixel)
	);

	a_fc_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= FC_W'(MAX_FRAMES))
		else $error("frame count beyond its maximum");

	a_no_transfer_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_s1 || !div_idle) |-> !in_acc)
		else $error("input transfer taken while a read is in progress");

	a_clear_resets_run: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (command == CMD_CLEAR)) |=> ((pos_q == '0) && (fc_q == '0) && !drop_q))
		else $error("clear did not restart the run");

	a_read_starts_divider: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1 |=> !div_idle)
		else $error("read did not reach the divider");

endmodule

`default_nettype wire

@@ dv/temporal_frame_averager_unit_tb.sv @@
// Self-checking testbench for the temporal frame averager: random and directed pixel traffic.
module temporal_frame_averager_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tfa_pkg::*;

	typedef enum logic [1:0] {
		CMD_ACCUM = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic [2:0] ADDR_FRAME_PIXELS = 3'h0;
	localparam logic [2:0] ADDR_MIN_FRAMES   = 3'h4;
	localparam int unsigned IDLE_LIMIT    = 5000;
	localparam int unsigned SETTLE_CYCLES = 40;

	typedef struct packed {
		cmd_t             cmd;
		logic [PIX_W-1:0] pix;
		logic             mv;
	} pixel_xfer_t;

	typedef struct packed {
		logic [PIX_W-1:0] average;
		logic             ready;
		logic             last;
	} avg_result_t;

	bit clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] command = '0;
	logic [PIX_W-1:0] pixel = '0;
	logic moved = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PIX_W-1:0] average;
	logic ready_res;
	logic last_pixel;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	temporal_frame_averager_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.pixel      (pixel),
		.moved      (moved),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.average    (average),
		.ready_res  (ready_res),
		.last_pixel (last_pixel),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pixel_xfer_t pending_xfers[$];
	avg_result_t expected_avgs[$];
	int unsigned sent_count = 0;
	int unsigned taken_count = 0;
	int unsigned fail_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned send_gap = 0;
	int unsigned recv_wait = 0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;
	bit in_fire = 1'b0;
	bit out_fire = 1'b0;
	pixel_xfer_t next_xfer;
	pixel_xfer_t seen_xfer;
	avg_result_t want;

	// Shadow of the frame store and control state.
	bit [SUM_W-1:0] frame_sums [MAX_PIXELS];
	bit sum_written [MAX_PIXELS];
	int unsigned cur_pos = 0;
	int unsigned frame_total = 0;
	bit drop_frame = 1'b0;
	int unsigned cfg_frame_pixels = MAX_PIXELS;
	int unsigned cfg_min_frames = 4;

	function automatic int unsigned frame_len();
		if (cfg_frame_pixels == 0) return 1;
		if (cfg_frame_pixels > MAX_PIXELS) return MAX_PIXELS;
		return cfg_frame_pixels;
	endfunction

	// Moves the shared position on; true when this was the frame's last pixel.
	function automatic bit step_position();
		if (cur_pos >= frame_len() - 1) begin
			cur_pos = 0;
			return 1'b1;
		end
		cur_pos++;
		return 1'b0;
	endfunction

	function automatic logic [PIX_W-1:0] rounded_average(int unsigned total, int unsigned cnt);
		int unsigned q;
		int unsigned r;
		if (cnt == 0) return '0;
		q = total / cnt;
		r = total % cnt;
		if (2 * r > cnt || (2 * r == cnt && q[0])) q++;
		if (q > 255) q = 255;
		return q[PIX_W-1:0];
	endfunction

	task automatic predict_transfer(input pixel_xfer_t x);
		avg_result_t res;
		int unsigned idx;
		idx = cur_pos;
		case (x.cmd)
			CMD_ACCUM: begin
				if (cur_pos == 0) begin
					if (frame_total == 0) begin
						drop_frame = 1'b0;
					end else if (x.mv) begin
						frame_total = 0;
						drop_frame = 1'b1;
					end else begin
						drop_frame = (frame_total >= MAX_FRAMES);
					end
				end
				if (!drop_frame) begin
					// Adding into an entry that was never overwritten leaves it undefined.
					if (frame_total == 0) begin
						frame_sums[idx] = SUM_W'(x.pix);
						sum_written[idx] = 1'b1;
					end else begin
						frame_sums[idx] = frame_sums[idx] + SUM_W'(x.pix);
					end
				end
				if (step_position() && !drop_frame && frame_total < MAX_FRAMES) frame_total++;
			end
			CMD_READ: begin
				res.average = rounded_average(32'(frame_sums[idx]), frame_total);
				res.ready = (frame_total > 0 && frame_total >= cfg_min_frames);
				res.last = step_position();
				expected_avgs.push_back(res);
			end
			CMD_CLEAR: begin
				frame_total = 0;
				cur_pos = 0;
				drop_frame = 1'b0;
			end
			default: begin
			end
		endcase
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_fire) begin
			// A stalled transfer keeps its payload.
		end else if (send_gap != 0) begin
			send_gap--;
			in_valid <= 1'b0;
		end else if (pending_xfers.size() != 0) begin
			next_xfer = pending_xfers.pop_front();
			command <= next_xfer.cmd;
			pixel <= next_xfer.pix;
			moved <= next_xfer.mv;
			in_valid <= 1'b1;
			if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
			send_gap = send_calm ? 0 : $urandom_range(0, 8);
		end else begin
			in_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (recv_wait != 0) begin
			out_stall <= 1'b1;
			if (out_valid) recv_wait--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			out_fire = out_valid && !out_stall;
			in_fire = in_valid && !in_stall;
			if (out_fire) begin
				if (expected_avgs.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result average %0d ready %0b last %0b",
							$time, average, ready_res, last_pixel);
				end else begin
					want = expected_avgs.pop_front();
					if (average !== want.average || ready_res !== want.ready ||
							last_pixel !== want.last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch average %0d/%0d ready %0b/%0b last %0b/%0b (exp/act)",
								$time, want.average, average, want.ready, ready_res,
								want.last, last_pixel);
					end
				end
				if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
				recv_wait = recv_calm ? 0 : $urandom_range(0, 8);
			end
			if (in_fire) begin
				seen_xfer.cmd = cmd_t'(command);
				seen_xfer.pix = pixel;
				seen_xfer.mv = moved;
				predict_transfer(seen_xfer);
				taken_count++;
			end
			if (in_fire || out_fire) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic send_item(input cmd_t c, input logic [PIX_W-1:0] p, input logic m);
		pixel_xfer_t x;
		x.cmd = c;
		x.pix = p;
		x.mv = m;
		pending_xfers.push_back(x);
		sent_count++;
		// Wait for acceptance so the shadow position is current for the next choice.
		wait (taken_count == sent_count);
	endtask

	// Never read an entry that has not been written; fill it instead.
	task automatic send_read(input logic m);
		if (sum_written[cur_pos]) send_item(CMD_READ, PIX_W'($urandom), m);
		else send_item(CMD_ACCUM, PIX_W'($urandom), m);
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel();
		if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return PIX_W'($urandom);
	endfunction

	function automatic logic pick_moved(input int unsigned pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (addr == ADDR_FRAME_PIXELS) cfg_frame_pixels = 32'(data[FP_W-1:0]);
		else cfg_min_frames = 32'(data[FC_W-1:0]);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain_results();
		wait (taken_count == sent_count);
		while (expected_avgs.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input int unsigned fp, input int unsigned minf);
		drain_results();
		apb_write(ADDR_FRAME_PIXELS, fp);
		apb_write(ADDR_MIN_FRAMES, minf);
	endtask

	task automatic random_traffic(input int unsigned n, input int unsigned pct);
		int unsigned done;
		int unsigned len;
		int unsigned r;
		cmd_t c;
		done = 0;
		while (done < n) begin
			r = $urandom_range(0, 99);
			len = $urandom_range(1, (frame_len() > 20) ? 40 : 2 * frame_len());
			if (r < 45) begin
				repeat (len) send_item(CMD_ACCUM, pick_pixel(), pick_moved(pct));
				done += len;
			end else if (r < 80) begin
				repeat (len) send_read(pick_moved(pct));
				done += len;
			end else if (r < 85) begin
				send_item(CMD_CLEAR, PIX_W'($urandom), 1'($urandom));
				done++;
			end else if (r < 90) begin
				send_item(CMD_NONE, PIX_W'($urandom), 1'($urandom));
			end else begin
				c = cmd_t'($urandom_range(0, 3));
				if (c == CMD_READ) send_read(1'($urandom));
				else send_item(c, pick_pixel(), 1'($urandom));
				if (c != CMD_NONE) done++;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Three-pixel frames: overwrite, moved drop, a second frame with ties, then clear.
		configure(3, 2);
		send_item(CMD_NONE, 8'hAA, 1'b1);
		send_item(CMD_ACCUM, 8'd255, 1'b0);
		send_item(CMD_ACCUM, 8'd0, 1'b0);
		send_item(CMD_ACCUM, 8'd128, 1'b0);
		repeat (3) send_item(CMD_READ, 8'd0, 1'b0);
		send_item(CMD_ACCUM, 8'd1, 1'b1);
		send_item(CMD_ACCUM, 8'd1, 1'b0);
		send_item(CMD_ACCUM, 8'd1, 1'b0);
		repeat (3) send_item(CMD_READ, 8'd0, 1'b0);
		send_item(CMD_ACCUM, 8'd0, 1'b1);
		send_item(CMD_ACCUM, 8'd255, 1'b0);
		send_item(CMD_ACCUM, 8'd127, 1'b0);
		send_item(CMD_ACCUM, 8'd255, 1'b0);
		send_item(CMD_ACCUM, 8'd255, 1'b0);
		send_item(CMD_ACCUM, 8'd128, 1'b0);
		repeat (3) send_item(CMD_READ, 8'd0, 1'b0);
		send_item(CMD_CLEAR, 8'd0, 1'b0);
		send_item(CMD_READ, 8'd0, 1'b0);

		// Single-pixel frames run past the frame count ceiling before random traffic.
		configure(1, 256);
		repeat (270) send_item(CMD_ACCUM, pick_pixel(), 1'b0);
		repeat (10) send_read(1'b0);
		random_traffic(250, 2);

		configure(4, 3);
		random_traffic(300, 10);
		configure(0, 0);
		random_traffic(150, 10);
		configure(7, 511);
		random_traffic(250, 8);
		configure(32'h7FFFF, 1);
		random_traffic(80, 10);
		configure(MAX_PIXELS, 2);
		random_traffic(60, 10);
		configure(13, 5);
		random_traffic(300, 5);
		configure(2, 1);
		random_traffic(250, 10);

		drain_results();
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ temporal_frame_averager_unit.f @@
src/tfa_pkg.sv
src/tfa_div.sv
src/temporal_frame_averager_unit.sv
dv/temporal_frame_averager_unit_tb.sv
